### rtl/lbd_pkg.sv
package lbd_pkg;

  // Sizing of the line buffer, the counters and the lanes.
  localparam int MAX_GROUPS  = 512;
  localparam int MAX_ROWS    = 2048;
  localparam int LANES       = 4;
  localparam int SAMPLE_BITS = 16;

  localparam int GRP_W      = $clog2(MAX_GROUPS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int GROUP_BITS = LANES * SAMPLE_BITS;

  // Configuration register widths.
  localparam int ROW_GROUPS_W = 10;
  localparam int FRAME_ROWS_W = 12;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 12;

  // Compare widths that hold both the register and the counter plus one.
  localparam int GC_W = (ROW_GROUPS_W > GRP_W + 1) ? ROW_GROUPS_W : GRP_W + 1;
  localparam int RC_W = (FRAME_ROWS_W > ROW_W + 1) ? FRAME_ROWS_W : ROW_W + 1;

  // Register reset values.
  localparam int ROW_GROUPS_RST = 180;
  localparam int FRAME_ROWS_RST = 480;

  // Result queue.
  localparam int OUTQ_DEPTH = 4;
  localparam int OQ_PTR_W   = $clog2(OUTQ_DEPTH);
  localparam int OQ_CNT_W   = $clog2(OUTQ_DEPTH + 1);

  // Output stream data width: row, group and samples, padded to bytes.
  localparam int OUT_FIELDS_W = ROW_W + GRP_W + GROUP_BITS;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_GROUPS = 2'd0,
    CFG_FRAME_ROWS = 2'd1,
    CFG_KEEP_TOP   = 2'd2,
    CFG_ROUND_UP   = 2'd3
  } cfg_idx_e;

  // One emitted group.
  typedef struct packed {
    logic [ROW_W-1:0]      row;
    logic [GRP_W-1:0]      grp;
    logic [GROUP_BITS-1:0] samples;
    logic                  done;
  } result_t;

  // Per-item control carried from the accept stage to the lane stage.
  typedef struct packed {
    logic             interp;
    logic             emit_cur;
    logic             done;
    logic [ROW_W-1:0] row;
    logic [GRP_W-1:0] grp;
  } item_ctrl_t;

endpackage

### rtl/lbd_linebuf.sv
module lbd_linebuf (
  input  logic                           clk_i,
  input  logic                           rd_en_i,
  input  logic                           wr_en_i,
  input  logic [lbd_pkg::GRP_W-1:0]      addr_i,
  input  logic [lbd_pkg::GROUP_BITS-1:0] wr_data_i,
  output logic [lbd_pkg::GROUP_BITS-1:0] rd_data_o
);

  logic [lbd_pkg::GROUP_BITS-1:0] mem [lbd_pkg::MAX_GROUPS];
  logic [lbd_pkg::GROUP_BITS-1:0] rd_data_q;

  // Read-first single port: a read returns the contents before a same-cycle write.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[addr_i];
    end
    if (wr_en_i) begin
      mem[addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/lbd_lane.sv
module lbd_lane (
  input  logic [lbd_pkg::SAMPLE_BITS-1:0] above_i,
  input  logic [lbd_pkg::SAMPLE_BITS-1:0] below_i,
  input  logic                            round_up_i,
  output logic [lbd_pkg::SAMPLE_BITS-1:0] avg_o
);

  logic [lbd_pkg::SAMPLE_BITS:0] sum;

  // Average of the two kept samples, with an optional half-up rounding bias.
  assign sum   = {1'b0, above_i} + {1'b0, below_i} + {{lbd_pkg::SAMPLE_BITS{1'b0}}, round_up_i};
  assign avg_o = sum[lbd_pkg::SAMPLE_BITS:1];

endmodule

### rtl/lbd_outq.sv
module lbd_outq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push0_i,
  input  logic                          push1_i,
  input  lbd_pkg::result_t              res0_i,
  input  lbd_pkg::result_t              res1_i,
  input  logic                          pop_ready_i,
  output logic                          head_valid_o,
  output lbd_pkg::result_t              head_o,
  output logic [lbd_pkg::OQ_CNT_W-1:0]  count_o
);

  lbd_pkg::result_t               entry_q [lbd_pkg::OUTQ_DEPTH];
  logic [lbd_pkg::OQ_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [lbd_pkg::OQ_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [lbd_pkg::OQ_CNT_W-1:0]   cnt_q, cnt_d;
  logic [lbd_pkg::OQ_PTR_W-1:0]   wr_ptr_nxt;
  logic [1:0]                     push_n;
  logic                           pop;

  assign push_n     = {1'b0, push0_i} + {1'b0, push1_i};
  assign pop        = head_valid_o && pop_ready_i;
  assign wr_ptr_nxt = wr_ptr_q + lbd_pkg::OQ_PTR_W'(1);

  // Pointer and fill-level bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q + lbd_pkg::OQ_PTR_W'(push_n);
    rd_ptr_d = pop ? rd_ptr_q + lbd_pkg::OQ_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + lbd_pkg::OQ_CNT_W'(push_n) - lbd_pkg::OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Up to two results enter per cycle, in order.
  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      entry_q[wr_ptr_q] <= res0_i;
    end
    if (push1_i) begin
      entry_q[wr_ptr_nxt] <= res1_i;
    end
  end

  assign head_valid_o = (cnt_q != '0);
  assign head_o       = entry_q[rd_ptr_q];
  assign count_o      = cnt_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lbd_pkg::OQ_CNT_W'(lbd_pkg::OUTQ_DEPTH))
    else $error("result queue fill level beyond depth");
  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push1_i |-> push0_i)
    else $error("second result pushed without the first");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cnt_q) + 32'(push_n)) <= lbd_pkg::OUTQ_DEPTH + 32'(pop))
    else $error("result queue overflow");
`endif

endmodule

### rtl/linear_blend_deinterlacer_core.sv
// An accepted group passes the lane stage register and then the result queue before its first result is offered.
// Throughput: one group per cycle, while the result stream does not stall, on rows that
// emit at most one result per group; kept rows below the first two emit an interpolated
// and a kept group each, so on those rows the single result port sets the pace.
// Reset: counters clear, registers take their defaults, the result queue empties;
// the line buffer is not cleared and needs no clearing pass.
module linear_blend_deinterlacer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input stream. tdata: sample_a, sample_b, sample_c, sample_d.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lbd_pkg::GROUP_BITS-1:0]   s_axis_tdata,
  // Result stream. tdata: out_row, out_group, out_a, out_b, out_c, out_d, zero pad.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lbd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast,
  // Configuration writes.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lbd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lbd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic [lbd_pkg::ROW_GROUPS_W-1:0] row_groups_q;
  logic [lbd_pkg::FRAME_ROWS_W-1:0] frame_rows_q;
  logic                             keep_top_q;
  logic                             round_up_q;

  logic [lbd_pkg::ROW_W-1:0]        row_q, row_d;
  logic [lbd_pkg::GRP_W-1:0]        grp_q, grp_d;

  logic [lbd_pkg::GC_W-1:0]         groups_sat;
  logic [lbd_pkg::RC_W-1:0]         rows_sat;
  logic                             last_grp, last_row, kept, accept;
  lbd_pkg::item_ctrl_t              ctrl;

  logic                             s1_valid_q;
  lbd_pkg::item_ctrl_t              s1_ctrl_q;
  logic [lbd_pkg::GROUP_BITS-1:0]   s1_samples_q;
  logic [1:0]                       s1_n;

  logic [lbd_pkg::GROUP_BITS-1:0]   above;
  logic [lbd_pkg::GROUP_BITS-1:0]   avg;
  lbd_pkg::result_t                 res0, res1, head;
  logic                             head_valid;
  logic [lbd_pkg::OQ_CNT_W-1:0]     q_count;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_groups_q <= lbd_pkg::ROW_GROUPS_W'(lbd_pkg::ROW_GROUPS_RST);
      frame_rows_q <= lbd_pkg::FRAME_ROWS_W'(lbd_pkg::FRAME_ROWS_RST);
      keep_top_q   <= 1'b1;
      round_up_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (lbd_pkg::cfg_idx_e'(cfg_index_i))
        lbd_pkg::CFG_ROW_GROUPS: row_groups_q <= cfg_data_i[lbd_pkg::ROW_GROUPS_W-1:0];
        lbd_pkg::CFG_FRAME_ROWS: frame_rows_q <= cfg_data_i[lbd_pkg::FRAME_ROWS_W-1:0];
        lbd_pkg::CFG_KEEP_TOP:   keep_top_q   <= cfg_data_i[0];
        lbd_pkg::CFG_ROUND_UP:   round_up_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Register values clamped to their legal ranges.
  always_comb begin
    if (row_groups_q == '0) begin
      groups_sat = lbd_pkg::GC_W'(1);
    end else if (lbd_pkg::GC_W'(row_groups_q) > lbd_pkg::GC_W'(lbd_pkg::MAX_GROUPS)) begin
      groups_sat = lbd_pkg::GC_W'(lbd_pkg::MAX_GROUPS);
    end else begin
      groups_sat = lbd_pkg::GC_W'(row_groups_q);
    end
    if (lbd_pkg::RC_W'(frame_rows_q) < lbd_pkg::RC_W'(2)) begin
      rows_sat = lbd_pkg::RC_W'(2);
    end else if (lbd_pkg::RC_W'(frame_rows_q) > lbd_pkg::RC_W'(lbd_pkg::MAX_ROWS)) begin
      rows_sat = lbd_pkg::RC_W'(lbd_pkg::MAX_ROWS);
    end else begin
      rows_sat = lbd_pkg::RC_W'(frame_rows_q);
    end
  end

  // Position and row class of the incoming group.
  assign last_grp = (lbd_pkg::GC_W'(grp_q) + lbd_pkg::GC_W'(1)) >= groups_sat;
  assign last_row = (lbd_pkg::RC_W'(row_q) + lbd_pkg::RC_W'(1)) >= rows_sat;
  assign kept     = (row_q[0] == ~keep_top_q);

  always_comb begin
    ctrl.interp   = kept && (row_q[lbd_pkg::ROW_W-1:1] != '0);
    ctrl.emit_cur = kept || (row_q == '0) || last_row;
    ctrl.done     = last_grp && last_row;
    ctrl.row      = row_q;
    ctrl.grp      = grp_q;
  end

  // Take a group only when the queue has room for everything in flight.
  assign s_axis_tready = (32'(q_count) + 32'(s1_n)) <= (lbd_pkg::OUTQ_DEPTH - 2);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Raster counters.
  always_comb begin
    grp_d = grp_q;
    row_d = row_q;
    if (accept) begin
      if (last_grp) begin
        grp_d = '0;
        row_d = last_row ? '0 : row_q + lbd_pkg::ROW_W'(1);
      end else begin
        grp_d = grp_q + lbd_pkg::GRP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      grp_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      row_q      <= row_d;
      grp_q      <= grp_d;
      s1_valid_q <= accept;
    end
  end

  // Lane stage payload; it waits for the line buffer read.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctrl_q    <= ctrl;
      s1_samples_q <= s_axis_tdata;
    end
  end

  // Line buffer holds the previous kept row, one word per group.
  lbd_linebuf u_linebuf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .wr_en_i   (accept && kept),
    .addr_i    (grp_q),
    .wr_data_i (s_axis_tdata),
    .rd_data_o (above)
  );

  // One averaging lane per sample of the group.
  for (genvar l = 0; l < lbd_pkg::LANES; l++) begin : g_lane
    lbd_lane u_lane (
      .above_i    (above[l*lbd_pkg::SAMPLE_BITS +: lbd_pkg::SAMPLE_BITS]),
      .below_i    (s1_samples_q[l*lbd_pkg::SAMPLE_BITS +: lbd_pkg::SAMPLE_BITS]),
      .round_up_i (round_up_q),
      .avg_o      (avg[l*lbd_pkg::SAMPLE_BITS +: lbd_pkg::SAMPLE_BITS])
    );
  end

  // Merge the lane outputs and the current group into up to two results.
  always_comb begin
    res1.row     = s1_ctrl_q.row;
    res1.grp     = s1_ctrl_q.grp;
    res1.samples = s1_samples_q;
    res1.done    = s1_ctrl_q.done;
    if (s1_ctrl_q.interp) begin
      res0.row     = s1_ctrl_q.row - lbd_pkg::ROW_W'(1);
      res0.grp     = s1_ctrl_q.grp;
      res0.samples = avg;
      res0.done    = 1'b0;
    end else begin
      res0 = res1;
    end
    if (!s1_valid_q) begin
      s1_n = 2'd0;
    end else if (s1_ctrl_q.interp) begin
      s1_n = 2'd2;
    end else begin
      s1_n = {1'b0, s1_ctrl_q.emit_cur};
    end
  end

  lbd_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push0_i      (s1_n != 2'd0),
    .push1_i      (s1_n == 2'd2),
    .res0_i       (res0),
    .res1_i       (res1),
    .pop_ready_i  (m_axis_tready),
    .head_valid_o (head_valid),
    .head_o       (head),
    .count_o      (q_count)
  );

  // Result stream packing.
  assign m_axis_tvalid = head_valid;
  assign m_axis_tlast  = head.done;
  assign m_axis_tdata  = {{(lbd_pkg::OUT_TDATA_W - lbd_pkg::OUT_FIELDS_W){1'b0}},
                          head.samples, head.grp, head.row};

`ifndef SYNTH
  a_interp_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_ctrl_q.interp) |-> (s1_ctrl_q.row[lbd_pkg::ROW_W-1:1] != '0))
    else $error("interpolated group issued for a row without a kept row above");
  a_stage_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted group did not reach the lane stage");
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("waiting result changed before its transfer");
`endif

endmodule

### tb/linear_blend_deinterlacer_core_tb.sv
`timescale 1ns / 1ps

module linear_blend_deinterlacer_core_tb;

  localparam int CLK_HALF      = 5;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_ITEMS  = 300;
  localparam int QUIET_FROM    = 240;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_REPORTS   = 10;

  // One group of samples; lane 0 sits in the low bits.
  typedef logic [lbd_pkg::LANES-1:0][lbd_pkg::SAMPLE_BITS-1:0] group_t;

  // One emitted group as it leaves the block.
  typedef struct packed {
    logic [lbd_pkg::ROW_W-1:0] row;
    logic [lbd_pkg::GRP_W-1:0] grp;
    group_t                    smp;
    logic                      done;
  } blend_result_t;

  // One line of stimulus: a register write or an input group.
  typedef struct {
    bit                bit_pad_unused_never;
  } unused_t;

  typedef struct {
    bit                is_cfg;
    lbd_pkg::cfg_idx_e idx;
    int                value;
    group_t            smp;
    bit                typed;
    int                n_exp;
    blend_result_t     exp0;
    blend_result_t     exp1;
  } stim_row_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [lbd_pkg::GROUP_BITS-1:0]  s_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [lbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [lbd_pkg::CFG_IDX_W-1:0]   cfg_index_i;
  logic [lbd_pkg::CFG_DATA_W-1:0]  cfg_data_i;

  // Predictor state: registers, counters and the kept-row line buffer.
  logic [lbd_pkg::ROW_GROUPS_W-1:0] cfg_groups;
  logic [lbd_pkg::FRAME_ROWS_W-1:0] cfg_rows;
  logic                             cfg_keep_top;
  logic                             cfg_round_up;
  logic [lbd_pkg::ROW_W-1:0]        pr_row;
  logic [lbd_pkg::GRP_W-1:0]        pr_grp;
  group_t                           line_store [lbd_pkg::MAX_GROUPS];

  blend_result_t expected_groups [$];
  stim_row_t     directed_rows [$];

  bit idle_on;
  int hold_requests;
  int holds_done;
  int stall_left;
  int cycle_count;
  int n_fail;
  int n_items;
  int n_results;
  int n_cfg;
  int n_midframe;

  linear_blend_deinterlacer_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always #CLK_HALF clk_i = ~clk_i;

  // Run limit in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d groups still expected.",
               cycle_count, expected_groups.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Output backpressure: random stall bursts plus one long hold on request.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready = 1'b0;
    end else if (holds_done < hold_requests) begin
      holds_done++;
      stall_left    = LONG_HOLD - 1;
      m_axis_tready = 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left    = $urandom_range(1, 16) - 1;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  function automatic void note_failure(input string msg);
    n_fail++;
    if (n_fail <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Effective bounds after saturation of the registers.
  function automatic int eff_groups();
    if (cfg_groups < 1) return 1;
    if (cfg_groups > lbd_pkg::MAX_GROUPS) return lbd_pkg::MAX_GROUPS;
    return int'(cfg_groups);
  endfunction

  function automatic int eff_rows();
    if (cfg_rows < 2) return 2;
    if (cfg_rows > lbd_pkg::MAX_ROWS) return lbd_pkg::MAX_ROWS;
    return int'(cfg_rows);
  endfunction

  // Advances the predictor by one accepted group and returns the groups it emits.
  function automatic int blend_step(input group_t cur, output blend_result_t r0,
                                    output blend_result_t r1);
    blend_result_t                 res [2];
    group_t                        avg;
    logic [lbd_pkg::SAMPLE_BITS:0] sum;
    logic                          last_grp;
    logic                          last_row;
    logic                          kept;
    int                            n;
    res[0]   = '0;
    res[1]   = '0;
    n        = 0;
    last_grp = (int'(pr_grp) + 1) >= eff_groups();
    last_row = (int'(pr_row) + 1) >= eff_rows();
    kept     = (pr_row[0] == !cfg_keep_top);
    if (kept) begin
      // A kept row below the second emits the missing row above it first.
      if (pr_row >= 2) begin
        for (int j = 0; j < lbd_pkg::LANES; j++) begin
          sum    = {1'b0, line_store[pr_grp][j]} + {1'b0, cur[j]} + cfg_round_up;
          avg[j] = sum[lbd_pkg::SAMPLE_BITS:1];
        end
        res[n] = '{row: pr_row - 1'b1, grp: pr_grp, smp: avg, done: 1'b0};
        n++;
      end
      line_store[pr_grp] = cur;
      res[n] = '{row: pr_row, grp: pr_grp, smp: cur, done: last_grp && last_row};
      n++;
    end else if (pr_row == 0 || last_row) begin
      // A missing row at the frame edge has no second neighbour and passes.
      res[n] = '{row: pr_row, grp: pr_grp, smp: cur, done: last_grp && last_row};
      n++;
    end
    if (last_grp) begin
      pr_grp = '0;
      pr_row = last_row ? '0 : pr_row + 1'b1;
    end else begin
      pr_grp = pr_grp + 1'b1;
    end
    r0 = res[0];
    r1 = res[1];
    return n;
  endfunction

  function automatic group_t mk_group(input int a, input int b, input int c, input int d);
    group_t g;
    g[0] = a[lbd_pkg::SAMPLE_BITS-1:0];
    g[1] = b[lbd_pkg::SAMPLE_BITS-1:0];
    g[2] = c[lbd_pkg::SAMPLE_BITS-1:0];
    g[3] = d[lbd_pkg::SAMPLE_BITS-1:0];
    return g;
  endfunction

  function automatic blend_result_t mk_res(input int row, input int grp, input int a,
                                           input int b, input int c, input int d,
                                           input bit done);
    blend_result_t r;
    r.row  = row[lbd_pkg::ROW_W-1:0];
    r.grp  = grp[lbd_pkg::GRP_W-1:0];
    r.smp  = mk_group(a, b, c, d);
    r.done = done;
    return r;
  endfunction

  function automatic stim_row_t item_row(input group_t smp, input int n,
                                         input blend_result_t e0, input blend_result_t e1);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = lbd_pkg::CFG_ROW_GROUPS;
    r.value  = 0;
    r.smp    = smp;
    r.typed  = 1'b1;
    r.n_exp  = n;
    r.exp0   = e0;
    r.exp1   = e1;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input lbd_pkg::cfg_idx_e idx, input int value);
    stim_row_t r;
    r        = item_row('0, 0, '0, '0);
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.value  = value;
    return r;
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 16'hFFFF;
      2:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t r;
    r       = item_row(mk_group(rand_sample(), rand_sample(), rand_sample(), rand_sample()),
                       0, '0, '0);
    r.typed = 1'b0;
    return r;
  endfunction

  // Register values for random frames; sizes stay small, the edges show up now and then.
  function automatic int pick_value(input lbd_pkg::cfg_idx_e idx);
    case (idx)
      lbd_pkg::CFG_ROW_GROUPS: begin
        case ($urandom_range(0, 9))
          0:       return 0;
          1:       return 1;
          2, 3:    return $urandom_range(7, 24);
          default: return $urandom_range(2, 6);
        endcase
      end
      lbd_pkg::CFG_FRAME_ROWS: begin
        case ($urandom_range(0, 9))
          0:       return $urandom_range(0, 1);
          1:       return $urandom_range(9, 14);
          default: return $urandom_range(2, 8);
        endcase
      end
      default: return $urandom_range(0, 1);
    endcase
  endfunction

  // Drops the input request and waits until every expected group has arrived.
  task automatic wait_drain();
    s_axis_tvalid = 1'b0;
    while (expected_groups.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Register write while the block is idle; entered and left at a falling edge.
  task automatic write_reg(input lbd_pkg::cfg_idx_e idx, input int value);
    wait_drain();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = lbd_pkg::CFG_DATA_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      lbd_pkg::CFG_ROW_GROUPS: cfg_groups   = lbd_pkg::ROW_GROUPS_W'(value);
      lbd_pkg::CFG_FRAME_ROWS: cfg_rows     = lbd_pkg::FRAME_ROWS_W'(value);
      lbd_pkg::CFG_KEEP_TOP:   cfg_keep_top = value[0];
      lbd_pkg::CFG_ROUND_UP:   cfg_round_up = value[0];
      default:                 ;
    endcase
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Offers one group, waits for its transfer and queues what it should produce.
  task automatic send_group(input stim_row_t r);
    blend_result_t p0;
    blend_result_t p1;
    int            n;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_axis_tdata  = r.smp;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    n = blend_step(r.smp, p0, p1);
    n_items++;
    if (r.typed) begin
      n  = r.n_exp;
      p0 = r.exp0;
      p1 = r.exp1;
    end
    if (n > 0) expected_groups.push_back(p0);
    if (n > 1) expected_groups.push_back(p1);
    @(negedge clk_i);
  endtask

  // Result checker: every output transfer against the oldest expected group.
  always @(posedge clk_i) begin
    blend_result_t got;
    blend_result_t want;
    logic [lbd_pkg::OUT_TDATA_W-lbd_pkg::OUT_FIELDS_W-1:0] pad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.row  = m_axis_tdata[lbd_pkg::ROW_W-1:0];
      got.grp  = m_axis_tdata[lbd_pkg::ROW_W +: lbd_pkg::GRP_W];
      got.smp  = m_axis_tdata[lbd_pkg::ROW_W+lbd_pkg::GRP_W +: lbd_pkg::GROUP_BITS];
      got.done = m_axis_tlast;
      pad      = m_axis_tdata[lbd_pkg::OUT_TDATA_W-1:lbd_pkg::OUT_FIELDS_W];
      n_results++;
      if (expected_groups.size() == 0) begin
        note_failure($sformatf("Unexpected group row %0d grp %0d samples %h last %0b",
                               got.row, got.grp, got.smp, got.done));
      end else begin
        want = expected_groups.pop_front();
        if (got.row !== want.row || got.grp !== want.grp || got.smp !== want.smp ||
            got.done !== want.done || pad !== '0) begin
          note_failure($sformatf({"Mismatch: expected row %0d grp %0d d/c/b/a %h last %0b,",
                                  " got row %0d grp %0d d/c/b/a %h last %0b pad %h"},
                                 want.row, want.grp, want.smp, want.done,
                                 got.row, got.grp, got.smp, got.done, pad));
        end
      end
    end
  end

  initial begin
    stim_row_t         r;
    int                rand_items;
    int                frame_len;
    int                cut;
    int                k;
    lbd_pkg::cfg_idx_e mid_idx;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = lbd_pkg::CFG_ROW_GROUPS;
    cfg_data_i    = '0;
    idle_on       = 1'b1;
    hold_requests = 0;
    rand_items    = 0;

    // Predictor starts from the reset state of the block.
    cfg_groups   = lbd_pkg::ROW_GROUPS_W'(lbd_pkg::ROW_GROUPS_RST);
    cfg_rows     = lbd_pkg::FRAME_ROWS_W'(lbd_pkg::FRAME_ROWS_RST);
    cfg_keep_top = 1'b1;
    cfg_round_up = 1'b0;
    pr_row       = '0;
    pr_grp       = '0;
    foreach (line_store[i]) line_store[i] = '0;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: reset defaults, saturated bounds, averaging extremes, both fields.
    directed_rows.push_back(item_row(mk_group('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF), 1,
                            mk_res(0, 0, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 0), '0));
    directed_rows.push_back(item_row(mk_group(0, 0, 0, 0), 1,
                            mk_res(0, 1, 0, 0, 0, 0, 0), '0));
    // Bounds below range saturate; the group counter now sits past the last group.
    directed_rows.push_back(cfg_row(lbd_pkg::CFG_ROW_GROUPS, 0));
    directed_rows.push_back(cfg_row(lbd_pkg::CFG_FRAME_ROWS, 1));
    directed_rows.push_back(item_row(mk_group('h1234, 'h5678, 'h9ABC, 'hDEF0), 1,
                            mk_res(0, 2, 'h1234, 'h5678, 'h9ABC, 'hDEF0, 0), '0));
    // Missing bottom row without a neighbour below passes and ends the frame.
    directed_rows.push_back(item_row(mk_group('hA5A5, 'h5A5A, 'h00FF, 'hFF00), 1,
                            mk_res(1, 0, 'hA5A5, 'h5A5A, 'h00FF, 'hFF00, 1), '0));
    // Three rows: the middle one is blended from its neighbours, floored.
    directed_rows.push_back(cfg_row(lbd_pkg::CFG_FRAME_ROWS, 3));
    directed_rows.push_back(item_row(mk_group('hFFFF, 0, 'hFFFF, 0), 1,
                            mk_res(0, 0, 'hFFFF, 0, 'hFFFF, 0, 0), '0));
    directed_rows.push_back(item_row(mk_group('h1111, 'h2222, 'h3333, 'h4444), 0, '0, '0));
    directed_rows.push_back(item_row(mk_group('hFFFF, 0, 0, 1), 2,
                            mk_res(1, 0, 'hFFFF, 0, 'h7FFF, 0, 0),
                            mk_res(2, 0, 'hFFFF, 0, 0, 1, 1)));
    // Same frame with rounding of halves upward.
    directed_rows.push_back(cfg_row(lbd_pkg::CFG_ROUND_UP, 1));
    directed_rows.push_back(item_row(mk_group('hFFFF, 0, 'hFFFF, 0), 1,
                            mk_res(0, 0, 'hFFFF, 0, 'hFFFF, 0, 0), '0));
    directed_rows.push_back(item_row(mk_group('h1111, 'h2222, 'h3333, 'h4444), 0, '0, '0));
    directed_rows.push_back(item_row(mk_group('hFFFF, 0, 0, 1), 2,
                            mk_res(1, 0, 'hFFFF, 0, 'h8000, 1, 0),
                            mk_res(2, 0, 'hFFFF, 0, 0, 1, 1)));
    // Bottom field kept: both even rows are at an edge and pass.
    directed_rows.push_back(cfg_row(lbd_pkg::CFG_KEEP_TOP, 0));
    directed_rows.push_back(item_row(mk_group(1, 2, 3, 4), 1,
                            mk_res(0, 0, 1, 2, 3, 4, 0), '0));
    directed_rows.push_back(item_row(mk_group('h8000, 'h7FFF, 'h8001, 'hFFFE), 1,
                            mk_res(1, 0, 'h8000, 'h7FFF, 'h8001, 'hFFFE, 0), '0));
    directed_rows.push_back(item_row(mk_group('hAAAA, 'h5555, 'hFFFF, 0), 1,
                            mk_res(2, 0, 'hAAAA, 'h5555, 'hFFFF, 0, 1), '0));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) write_reg(directed_rows[i].idx, directed_rows[i].value);
      else send_group(directed_rows[i]);
    end

    // Widest row (group count saturates high) under a long output stall; this also
    // fills every line buffer entry, so later mid-frame changes read only written data.
    write_reg(lbd_pkg::CFG_KEEP_TOP, 1);
    write_reg(lbd_pkg::CFG_ROUND_UP, 0);
    write_reg(lbd_pkg::CFG_FRAME_ROWS, 2);
    write_reg(lbd_pkg::CFG_ROW_GROUPS, 1023);
    @(posedge clk_i);
    hold_requests++;
    @(negedge clk_i);
    repeat (lbd_pkg::MAX_GROUPS + 5) send_group(random_row());
    write_reg(lbd_pkg::CFG_ROW_GROUPS, 3);
    n_midframe++;
    while (pr_row != 0 || pr_grp != 0) send_group(random_row());

    // Tallest frame, cut short by shrinking the row count mid-frame.
    write_reg(lbd_pkg::CFG_ROW_GROUPS, 1);
    write_reg(lbd_pkg::CFG_FRAME_ROWS, 4095);
    write_reg(lbd_pkg::CFG_ROUND_UP, 1);
    repeat ($urandom_range(18, 30)) send_group(random_row());
    write_reg(lbd_pkg::CFG_FRAME_ROWS, 6);
    n_midframe++;
    while (pr_row != 0 || pr_grp != 0) send_group(random_row());

    // Random frames with random settings, some reconfigured mid-frame.
    while (rand_items < RANDOM_ITEMS) begin
      idle_on = (rand_items < QUIET_FROM) ? ($urandom_range(0, 4) != 0) : 1'b0;
      if ($urandom_range(0, 1))
        write_reg(lbd_pkg::CFG_ROW_GROUPS, pick_value(lbd_pkg::CFG_ROW_GROUPS));
      if ($urandom_range(0, 1))
        write_reg(lbd_pkg::CFG_FRAME_ROWS, pick_value(lbd_pkg::CFG_FRAME_ROWS));
      if ($urandom_range(0, 1))
        write_reg(lbd_pkg::CFG_KEEP_TOP, pick_value(lbd_pkg::CFG_KEEP_TOP));
      if ($urandom_range(0, 1))
        write_reg(lbd_pkg::CFG_ROUND_UP, pick_value(lbd_pkg::CFG_ROUND_UP));
      frame_len = eff_groups() * eff_rows();
      cut = (frame_len > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, frame_len - 1) : 0;
      k = 0;
      do begin
        if (cut != 0 && k == cut) begin
          mid_idx = lbd_pkg::cfg_idx_e'($urandom_range(0, 3));
          write_reg(mid_idx, pick_value(mid_idx));
          n_midframe++;
        end
        send_group(random_row());
        k++;
        rand_items++;
      end while (pr_row != 0 || pr_grp != 0);
      // Now and then the sender waits for the block to empty.
      if ($urandom_range(0, 5) == 0) wait_drain();
    end

    // Let the last results out and give any extra output time to show up.
    wait_drain();
    repeat (16) @(posedge clk_i);
    if (expected_groups.size() != 0)
      note_failure($sformatf("%0d expected groups never arrived", expected_groups.size()));

    $display("Covered %0d input groups and %0d output groups across %0d register writes,",
             n_items, n_results, n_cfg);
    $display("with %0d changes inside a frame, saturated bounds and a %0d-cycle output hold.",
             n_midframe, LONG_HOLD);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d failures in total.", n_fail);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/lbd_pkg.sv
rtl/lbd_linebuf.sv
rtl/lbd_lane.sv
rtl/lbd_outq.sv
rtl/linear_blend_deinterlacer_core.sv
tb/linear_blend_deinterlacer_core_tb.sv
